// File: rtl/core/scfla_pkg.sv
package scfla_pkg;

  localparam int DEF_MAX_BLOCK_BYTES = 128;
  localparam int DEF_GAP_BYTES       = 8;
  localparam int DEF_CHAIN_BLOCKS    = 20;
  localparam int DEF_HEADER_BYTES    = 8;
  localparam int DEF_ARENA_BYTES     = 65536;

  localparam int ADDR_W     = 16;
  localparam int ADDR_SPACE = 1 << ADDR_W;
  localparam int CP_W       = ADDR_W + 1;
  localparam int LINK_W     = ADDR_W + 1;
  localparam int COUNT_W    = 16;
  localparam int ELEM_W     = 8;
  localparam int BYTES_W    = COUNT_W + ELEM_W;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERSIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_ZERO      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_HEAD,
    S_CARVE,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic free_push;
    logic carve_push;
    logic pop_read;
    logic pop_load;
    logic set_exhausted;
    logic load_out;
  } scfla_ctl_t;

  typedef struct packed {
    logic is_free;
    logic zero;
    logic oversize;
    logic head_valid;
    logic carve_fit;
    logic slot_free;
  } scfla_stat_t;

endpackage

// File: rtl/core/scfla_ctrl.sv
module scfla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scfla_pkg::scfla_stat_t stat,
  output scfla_pkg::scfla_ctl_t  ctl
);
  import scfla_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_CLASS;
        end
      end
      S_CLASS: begin
        ctl.classify = 1'b1;
        state_nxt    = S_HEAD;
      end
      S_HEAD: begin
        if (stat.zero || stat.oversize) begin
          state_nxt = S_DONE;
        end else if (stat.is_free) begin
          ctl.free_push = 1'b1;
          state_nxt     = S_DONE;
        end else if (stat.head_valid) begin
          ctl.pop_read = 1'b1;
          state_nxt    = S_POP;
        end else begin
          state_nxt = S_CARVE;
        end
      end
      S_CARVE: begin
        if (stat.carve_fit) begin
          ctl.carve_push = 1'b1;
        end else if (stat.head_valid) begin
          ctl.pop_read = 1'b1;
          state_nxt    = S_POP;
        end else begin
          ctl.set_exhausted = 1'b1;
          state_nxt         = S_DONE;
        end
      end
      S_POP: begin
        ctl.pop_load = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (stat.slot_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/scfla_dp.sv
module scfla_dp #(
  parameter int MAX_BLOCK_BYTES = scfla_pkg::DEF_MAX_BLOCK_BYTES,
  parameter int GAP_BYTES       = scfla_pkg::DEF_GAP_BYTES,
  parameter int CHAIN_BLOCKS    = scfla_pkg::DEF_CHAIN_BLOCKS,
  parameter int HEADER_BYTES    = scfla_pkg::DEF_HEADER_BYTES,
  parameter int ARENA_BYTES     = scfla_pkg::DEF_ARENA_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [scfla_pkg::ELEM_W-1:0]      cfg_wdata,
  input  logic                              in_cmd,
  input  logic [scfla_pkg::COUNT_W-1:0]     in_count,
  input  logic [scfla_pkg::ADDR_W-1:0]      in_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scfla_pkg::ADDR_W-1:0]      out_addr_res,
  output logic [1:0]                        out_status,
  input  scfla_pkg::scfla_ctl_t             ctl,
  output scfla_pkg::scfla_stat_t            stat
);
  import scfla_pkg::*;

  localparam int NUM_CLASSES = (MAX_BLOCK_BYTES - 1) / GAP_BYTES + 1;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int XN          = $clog2(MAX_BLOCK_BYTES);
  localparam int KSH         = XN + $clog2(GAP_BYTES);
  localparam int RECIP       = ((1 << KSH) + GAP_BYTES - 1) / GAP_BYTES;
  localparam int RW          = XN + 2;
  localparam int PW          = XN + RW;
  localparam int LIMIT       = (ARENA_BYTES < ADDR_SPACE) ? ARENA_BYTES : ADDR_SPACE;
  localparam int CNT_W       = $clog2(CHAIN_BLOCKS + 1);

  logic [ELEM_W-1:0]      elem_r;
  cmd_t                   cmd_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [BYTES_W-1:0]     bytes_r;
  logic [CLS_W-1:0]       cls_r;
  logic [CP_W-1:0]        bsize_r;
  logic [CP_W-1:0]        cp_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [ADDR_W-1:0]      head_r [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] hvalid_r;
  logic [LINK_W-1:0]      link_mem [ADDR_SPACE];
  logic [LINK_W-1:0]      rdata_r;
  logic [ADDR_W-1:0]      res_r;
  status_t                status_r;
  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  status_t                out_status_r;

  logic [BYTES_W-1:0] bytes_m1;
  logic [XN-1:0]      xm1;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      prod_sh;
  logic [CLS_W-1:0]   cls_nxt;
  logic               zero;
  logic               oversize;
  logic [ADDR_W-1:0]  head_sel;
  logic               hv_sel;
  logic               push_en;
  logic [ADDR_W-1:0]  push_blk;
  logic [CP_W:0]      carve_end;
  logic               slot_free;

  assign zero     = (bytes_r == '0);
  assign oversize = (bytes_r > BYTES_W'(MAX_BLOCK_BYTES));
  assign bytes_m1 = bytes_r - BYTES_W'(1);
  assign xm1      = bytes_m1[XN-1:0];
  assign prod     = PW'(xm1) * PW'(RECIP);
  assign prod_sh  = prod >> KSH;
  assign cls_nxt  = prod_sh[CLS_W-1:0];

  assign head_sel  = head_r[cls_r];
  assign hv_sel    = hvalid_r[cls_r];
  assign push_en   = ctl.free_push | ctl.carve_push;
  assign push_blk  = ctl.carve_push ? cp_r[ADDR_W-1:0] : (addr_r - ADDR_W'(HEADER_BYTES));
  assign carve_end = {1'b0, cp_r} + {1'b0, bsize_r};
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    stat            = '0;
    stat.is_free    = (cmd_r == CMD_FREE);
    stat.zero       = zero;
    stat.oversize   = oversize;
    stat.head_valid = hv_sel;
    stat.carve_fit  = (cnt_r < CNT_W'(CHAIN_BLOCKS)) && (carve_end <= (CP_W + 1)'(LIMIT));
    stat.slot_free  = slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r      <= ELEM_W'(1);
      cp_r        <= '0;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        elem_r <= cfg_wdata;
      end
      if (ctl.carve_push) begin
        cp_r <= carve_end[CP_W-1:0];
      end
      if (push_en) begin
        hvalid_r[cls_r] <= 1'b1;
      end else if (ctl.pop_load) begin
        hvalid_r[cls_r] <= rdata_r[ADDR_W];
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bsize_r <= CP_W'(HEADER_BYTES) + CP_W'(GAP_BYTES) * (CP_W'(cls_r) + CP_W'(1));
    if (ctl.capture) begin
      cmd_r   <= cmd_t'(in_cmd);
      addr_r  <= in_addr;
      bytes_r <= BYTES_W'(in_count) * BYTES_W'(elem_r);
    end
    if (ctl.classify) begin
      cls_r <= cls_nxt;
      cnt_r <= '0;
      res_r <= '0;
      if (zero) begin
        status_r <= ST_ZERO;
      end else if (oversize) begin
        status_r <= ST_OVERSIZE;
      end else begin
        status_r <= ST_OK;
      end
    end
    if (ctl.carve_push) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (ctl.set_exhausted) begin
      status_r <= ST_EXHAUSTED;
    end
    if (push_en) begin
      head_r[cls_r] <= push_blk;
    end else if (ctl.pop_load) begin
      head_r[cls_r] <= rdata_r[ADDR_W-1:0];
      res_r         <= head_sel + ADDR_W'(HEADER_BYTES);
    end
    if (ctl.load_out) begin
      out_addr_r   <= res_r;
      out_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      link_mem[push_blk] <= {hv_sel, head_sel};
    end
    if (ctl.pop_read) begin
      rdata_r <= link_mem[head_sel];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_addr_res = out_addr_r;
  assign out_status   = out_status_r;

endmodule

// File: rtl/core/size_class_free_list_allocator_unit.sv
// Segregated free-list allocator over a fixed byte arena. Each item is an allocate or a free of
// count elements of the configured element size; the byte size picks a size class, and each
// class keeps a last-in first-out list of free blocks whose links live in a 64K-entry link
// memory indexed by block address. A sequencer handles one item at a time: a free, or any
// request rejected as zero-sized or oversize, goes from the classify and head-check states
// straight to the done state, and an allocate served from a non-empty list first reads the head
// block's link and pops it. An allocate that finds its list empty first carves new blocks from
// the bump pointer, one block per cycle, up to the chain length, and then pops one of them, or
// reports the arena exhausted when it has no room left for a single block. The next item is
// accepted once the result has moved into the output register, which holds it until taken. No
// clearing pass is needed after reset.
module size_class_free_list_allocator_unit #(
  parameter int MAX_BLOCK_BYTES = scfla_pkg::DEF_MAX_BLOCK_BYTES,
  parameter int GAP_BYTES       = scfla_pkg::DEF_GAP_BYTES,
  parameter int CHAIN_BLOCKS    = scfla_pkg::DEF_CHAIN_BLOCKS,
  parameter int HEADER_BYTES    = scfla_pkg::DEF_HEADER_BYTES,
  parameter int ARENA_BYTES     = scfla_pkg::DEF_ARENA_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scfla_pkg::ELEM_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [scfla_pkg::COUNT_W-1:0] in_count,
  input  logic [scfla_pkg::ADDR_W-1:0]  in_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scfla_pkg::ADDR_W-1:0]  out_addr_res,
  output logic [1:0]                    out_status
);
  import scfla_pkg::*;

  scfla_ctl_t  ctl;
  scfla_stat_t stat;

  scfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  scfla_dp #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .GAP_BYTES       (GAP_BYTES),
    .CHAIN_BLOCKS    (CHAIN_BLOCKS),
    .HEADER_BYTES    (HEADER_BYTES),
    .ARENA_BYTES     (ARENA_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_cmd       (in_cmd),
    .in_count     (in_count),
    .in_addr      (in_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_addr_res (out_addr_res),
    .out_status   (out_status),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule
